FILE: rtl/core/signed_number_to_digit_codes_top_assert.svh
// Assertion macros used by the checker module of this block.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef SIGNED_NUMBER_TO_DIGIT_CODES_TOP_ASSERT_SVH
`define SIGNED_NUMBER_TO_DIGIT_CODES_TOP_ASSERT_SVH

// Same-cycle implication.
`define SDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and constants of the signed number to digit codes block.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam logic [7:0] DECODE_FLAG = 8'h10;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [7:0] DASH_CODE   = 8'h1A;
  localparam logic [7:0] POINT_BIT   = 8'h80;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_DASH     = 2'd1;
  localparam logic [1:0] STATUS_POINT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CFG_DIGITS_IN_USE   = 2'd0,
    CFG_PADDING_CODE    = 2'd1,
    CFG_PADDING_DECODED = 2'd2,
    CFG_FRACTION_DIGITS = 2'd3
  } cfg_idx_e;

  // Control of the BCD cell chain.
  typedef struct packed {
    logic clear;  // zero all digits
    logic shift;  // one shift-add step
  } chain_ctrl_t;

endpackage

FILE: rtl/core/signed_number_to_digit_codes_top.sv
// ----------------------------------------------------------------------------
// signed_number_to_digit_codes_top
// Converts a signed number into one display code per digit position.
// ----------------------------------------------------------------------------
// Operation: the magnitude shifts bit-serially through the BCD cell chain,
// a setup state (ST_CALC) lays out the run, then the first result item
// comes; the rest follow one per cycle while the output is not stalled.
// A new number is taken only once the run has ended.
// Reset: configuration returns to 8 positions, padding 15 decoded, no point.
// ----------------------------------------------------------------------------
module signed_number_to_digit_codes_top
  import sdc_pkg::*;
#(
  parameter int MAX_DIGITS  = 8,
  parameter int NUMBER_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] number_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [3:0] position, [11:4] char_code, zero
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int         IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int         BIT_W = $clog2(NUMBER_BITS);
  localparam logic [4:0] MAX_N = 5'(MAX_DIGITS);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_CALC, ST_EMIT} state_e;

  state_e state_q;

  // configuration
  logic [4:0] dig_use_q;
  logic [7:0] pad_code_q;
  logic       pad_dec_q;
  logic [4:0] frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_use_q  <= 5'd8;
      pad_code_q <= 8'd15;
      pad_dec_q  <= 1'b1;
      frac_q     <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIGITS_IN_USE:   dig_use_q  <= cfg_data_i[4:0];
        CFG_PADDING_CODE:    pad_code_q <= cfg_data_i;
        CFG_PADDING_DECODED: pad_dec_q  <= cfg_data_i[0];
        CFG_FRACTION_DIGITS: frac_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // input magnitude
  logic [NUMBER_BITS+31:0] in_ext;
  logic [NUMBER_BITS-1:0]  raw;
  logic [NUMBER_BITS-1:0]  mag_w;
  logic                    in_acc;

  assign in_ext = {{NUMBER_BITS{1'b0}}, s_axis_tdata_i};
  assign raw    = in_ext[NUMBER_BITS-1:0];
  assign mag_w  = raw[NUMBER_BITS-1] ? (~raw + 1'b1) : raw;
  assign in_acc = (state_q == ST_IDLE) && s_axis_tvalid_i;

  logic [NUMBER_BITS-1:0] mag_q;
  logic                   neg_q;
  logic [4:0]             n_q;
  logic [4:0]             kc_q;
  logic [4:0]             d_q;
  logic [1:0]             stat_q;
  logic                   pt_q;
  logic [BIT_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       pos_q;

  // BCD chain
  chain_ctrl_t ctrl;
  logic [3:0]  digits [MAX_DIGITS];
  logic        ovf;

  assign ctrl.clear = in_acc;
  assign ctrl.shift = (state_q == ST_CONV);

  sdc_bcd_chain #(.MAX_DIGITS(MAX_DIGITS)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .bit_i   (mag_q[NUMBER_BITS-1]),
    .digits_o(digits),
    .ovf_o   (ovf)
  );

  // layout of the run: digit count, end of zero fill, status
  logic [4:0] k_w;
  logic [4:0] kc_w;
  logic [4:0] fz_w;
  logic [4:0] d_w;
  logic [1:0] stat_w;

  always_comb begin
    k_w = 5'd0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[i] != 4'd0) k_w = 5'(i + 1);
    end
    kc_w = (ovf || (k_w > n_q)) ? n_q : k_w;
    fz_w = (frac_q >= n_q) ? n_q : (frac_q + 5'd1);
    d_w  = (kc_w > fz_w) ? kc_w : fz_w;
    if (neg_q && (d_w >= n_q)) begin
      stat_w = STATUS_NO_DASH;
    end else if ((frac_q != 5'd0) && (frac_q >= n_q)) begin
      stat_w = STATUS_POINT_RANGE;
    end else begin
      stat_w = STATUS_OK;
    end
  end

  // code of the current position
  logic [4:0] p5;
  logic [7:0] pad;
  logic [7:0] code;
  logic       last_w;
  logic       load;

  assign p5     = 5'(pos_q);
  assign pad    = pad_dec_q ? (pad_code_q | DECODE_FLAG) : (pad_code_q & LOW_NIBBLE);
  assign last_w = ((p5 + 5'd1) == n_q);
  assign load   = (state_q == ST_EMIT) && (!m_axis_tvalid_o || m_axis_tready_i);

  always_comb begin
    if (p5 < kc_q) begin
      code = DECODE_FLAG | {4'd0, digits[pos_q]};
    end else if (p5 < d_q) begin
      code = DECODE_FLAG;
    end else if ((p5 == d_q) && neg_q) begin
      code = DASH_CODE;
    end else begin
      code = pad;
    end
    if (pt_q && (p5 == frac_q)) code = code | POINT_BIT;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q <= mag_w;
      neg_q <= raw[NUMBER_BITS-1];
      n_q   <= (dig_use_q > MAX_N) ? MAX_N : dig_use_q;
    end else if (state_q == ST_CONV) begin
      mag_q <= {mag_q[NUMBER_BITS-2:0], 1'b0};
    end
    if (state_q == ST_CALC) begin
      kc_q   <= kc_w;
      d_q    <= d_w;
      stat_q <= stat_w;
      pt_q   <= (stat_w == STATUS_OK) && (frac_q != 5'd0);
    end
  end

  // control and output register
  logic [3:0] m_pos_q;
  logic [7:0] m_code_q;
  logic       m_last_q;
  logic [1:0] m_stat_q;
  logic       m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_pos_q   <= 4'd0;
      m_code_q  <= 8'd0;
      m_last_q  <= 1'b0;
      m_stat_q  <= STATUS_OK;
    end else begin
      // drop the item once taken, unless a new one loads in its place
      if (m_valid_q && m_axis_tready_i && !load) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cnt_q   <= BIT_W'(NUMBER_BITS - 1);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_CALC;
        end
        ST_CALC: begin
          pos_q   <= '0;
          state_q <= (n_q == 5'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            m_valid_q <= 1'b1;
            m_pos_q   <= 4'(pos_q);
            m_code_q  <= code;
            m_last_q  <= last_w;
            m_stat_q  <= last_w ? stat_q : STATUS_OK;
            pos_q     <= pos_q + 1'b1;
            if (last_w) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'd0, m_code_q, m_pos_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_stat_q;

endmodule

FILE: rtl/core/sdc_bcd_cell.sv
// ----------------------------------------------------------------------------
// sdc_bcd_cell
// One decimal digit of the shift-add converter: add 3 when five or more,
// then shift one bit in from below and pass the top bit up.
// ----------------------------------------------------------------------------
module sdc_bcd_cell
  import sdc_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        bit_i,
  output logic        bit_o,
  output logic [3:0]  digit_o
);

  logic [3:0] digit_q;
  logic [3:0] adj;

  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      digit_q <= 4'd0;
    end else if (ctrl_i.shift) begin
      digit_q <= {adj[2:0], bit_i};
    end
  end

endmodule

FILE: rtl/core/sdc_bcd_chain.sv
// ----------------------------------------------------------------------------
// sdc_bcd_chain
// Row of BCD cells, least significant digit first. Flags overflow when a
// one leaves the top cell, meaning a nonzero digit exists above the row.
// ----------------------------------------------------------------------------
module sdc_bcd_chain
  import sdc_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  logic        bit_i,
  output logic [3:0]  digits_o [MAX_DIGITS],
  output logic        ovf_o
);

  logic [MAX_DIGITS:0] carry;
  logic                ovf_q;

  assign carry[0] = bit_i;
  assign ovf_o    = ovf_q;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    sdc_bcd_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .bit_i  (carry[i]),
      .bit_o  (carry[i+1]),
      .digit_o(digits_o[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      ovf_q <= 1'b0;
    end else if (ctrl_i.shift && carry[MAX_DIGITS]) begin
      ovf_q <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks of the signed number to digit codes block.
// ----------------------------------------------------------------------------
`include "signed_number_to_digit_codes_top_assert.svh"

module sdc_checker
  import sdc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [1:0]  m_axis_tuser_o
);

  logic        in_fire;
  logic        out_fire;
  logic        out_stall;
  logic        mid_item;
  logic [18:0] out_word;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign mid_item  = m_axis_tvalid_o && !m_axis_tlast_o;
  assign out_word  = {m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o};

  // status is reported on the last item of a run only
  `SDC_ASSERT_IMP(a_status_on_last, mid_item, m_axis_tuser_o == STATUS_OK, "early status")

  // a stalled item holds
  `SDC_ASSERT_NXT(a_hold, out_stall, m_axis_tvalid_o && $stable(out_word), "item changed")

  // one number at a time: ready drops after an accept
  `SDC_ASSERT_NXT(a_one_at_a_time, in_fire, !s_axis_tready_o, "ready held after accept")

  // a run streams without gaps until its last item
  `SDC_ASSERT_NXT(a_run_no_gap, out_fire && !m_axis_tlast_o, m_axis_tvalid_o, "gap inside a run")

endmodule

bind signed_number_to_digit_codes_top sdc_checker u_sdc_checker (.*);
